@@ rtl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg: shared definitions for the complex arithmetic unit
// Operation codes, the fixed field width and the control bundle that travels
// with each item down the pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int FIELD_BITS = 32;
	localparam int CMD_BITS   = 3;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_ADD  = 3'd0,
		CMD_SUB  = 3'd1,
		CMD_MUL  = 3'd2,
		CMD_DIV  = 3'd3,
		CMD_CONJ = 3'd4,
		CMD_MAG  = 3'd5
	} cmd_t;

	// Per-item control bits carried alongside the data path.
	typedef struct packed {
		logic is_div;
		logic dz;
		logic neg_re;
		logic neg_im;
		logic ovf_re;
		logic ovf_im;
	} ctl_t;

endpackage

@@ rtl/cau_front.sv @@
// ----------------------------------------------------------------------------
// cau_front: operand capture, products, combination and divider setup
// Four pipeline stages: products, per-operation sums, magnitude and sign of
// the divide numerators, then the quotient overflow check and the initial
// partial remainder.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	output logic                  stall,
	input  logic [CMD_BITS-1:0]   cmd,
	input  logic [FIELD_BITS-1:0] a_re,
	input  logic [FIELD_BITS-1:0] a_im,
	input  logic [FIELD_BITS-1:0] b_re,
	input  logic [FIELD_BITS-1:0] b_im,
	input  logic                  accept,
	output logic                  valid_s4,
	output ctl_t                  ctl_s4,
	output logic signed [2*W+1:0] val_re_s4,
	output logic signed [2*W+1:0] val_im_s4,
	output logic [2*W-1:0]        den_s4,
	output logic [2*W-1:0]        rem_re_s4,
	output logic [2*W-1:0]        rem_im_s4,
	output logic [W:0]            q_re_s4,
	output logic [W:0]            q_im_s4
);

	localparam int W2  = 2 * W;
	localparam int VB  = 2 * W + 2;
	localparam int DW  = 2 * W;
	localparam int QB  = W + 1;
	localparam int TW  = W + F - 1;
	localparam int CW  = (TW > DW) ? TW : DW;
	localparam int DVW = DW + F;

	logic rdy1, rdy2, rdy3, rdy4;

	// Stage 1 registers.
	logic                 valid_s1;
	cmd_t                 cmd_s1;
	logic signed [W-1:0]  ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [W2-1:0] prr_s1, pii_s1, pri_s1, pir_s1, sqr_s1, sqi_s1;
	logic                 bz_s1;

	// Stage 2 registers.
	logic                 valid_s2;
	ctl_t                 ctl_s2;
	logic signed [VB-1:0] val_re_s2, val_im_s2;
	logic [DW-1:0]        den_s2;

	// Stage 3 registers.
	logic                 valid_s3;
	ctl_t                 ctl_s3;
	logic signed [VB-1:0] val_re_s3, val_im_s3;
	logic [DW-1:0]        den_s3, mag_re_s3, mag_im_s3;

	assign rdy4  = !valid_s4 || accept;
	assign rdy3  = !valid_s3 || rdy4;
	assign rdy2  = !valid_s2 || rdy3;
	assign rdy1  = !valid_s1 || rdy2;
	assign stall = !rdy1;

	// Stage 1: operands and all products.
	logic signed [W-1:0] ar, ai, br, bi, sx, sy;
	logic                is_mag;

	assign ar     = a_re[W-1:0];
	assign ai     = a_im[W-1:0];
	assign br     = b_re[W-1:0];
	assign bi     = b_im[W-1:0];
	assign is_mag = (cmd == CMD_MAG);
	assign sx     = is_mag ? ar : br;
	assign sy     = is_mag ? ai : bi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy1) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && valid) begin
			cmd_s1 <= cmd_t'(cmd);
			ar_s1  <= ar;
			ai_s1  <= ai;
			br_s1  <= br;
			bi_s1  <= bi;
			prr_s1 <= W2'(ar) * W2'(br);
			pii_s1 <= W2'(ai) * W2'(bi);
			pri_s1 <= W2'(ar) * W2'(bi);
			pir_s1 <= W2'(ai) * W2'(br);
			sqr_s1 <= W2'(sx) * W2'(sx);
			sqi_s1 <= W2'(sy) * W2'(sy);
			bz_s1  <= (br == '0) && (bi == '0);
		end
	end

	// Stage 2: sums per operation; multiply and magnitude results are floored here.
	logic signed [VB-1:0] re_c, im_c, sum_a, sum_b;
	logic [DW-1:0]        den_c;
	ctl_t                 ctl_c;

	always_comb begin
		sum_a = '0;
		sum_b = '0;
		re_c  = '0;
		im_c  = '0;
		case (cmd_s1)
			CMD_ADD: begin
				re_c = VB'(ar_s1) + VB'(br_s1);
				im_c = VB'(ai_s1) + VB'(bi_s1);
			end
			CMD_SUB: begin
				re_c = VB'(ar_s1) - VB'(br_s1);
				im_c = VB'(ai_s1) - VB'(bi_s1);
			end
			CMD_MUL: begin
				sum_a = VB'(prr_s1) - VB'(pii_s1);
				sum_b = VB'(pri_s1) + VB'(pir_s1);
				re_c  = sum_a >>> F;
				im_c  = sum_b >>> F;
			end
			CMD_DIV: begin
				re_c = VB'(prr_s1) + VB'(pii_s1);
				im_c = VB'(pir_s1) - VB'(pri_s1);
			end
			CMD_CONJ: begin
				re_c = VB'(ar_s1);
				im_c = -VB'(ai_s1);
			end
			CMD_MAG: begin
				sum_a = VB'(sqr_s1) + VB'(sqi_s1);
				re_c  = sum_a >>> F;
			end
			default: begin
				re_c = '0;
				im_c = '0;
			end
		endcase
		den_c        = $unsigned(sqr_s1) + $unsigned(sqi_s1);
		ctl_c        = '0;
		ctl_c.is_div = (cmd_s1 == CMD_DIV);
		ctl_c.dz     = (cmd_s1 == CMD_DIV) && bz_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			ctl_s2    <= ctl_c;
			val_re_s2 <= re_c;
			val_im_s2 <= im_c;
			den_s2    <= den_c;
		end
	end

	// Stage 3: sign and magnitude of the divide numerators.
	logic signed [VB-1:0] abs_re, abs_im;
	ctl_t                 ctl_m;

	always_comb begin
		abs_re       = val_re_s2[VB-1] ? -val_re_s2 : val_re_s2;
		abs_im       = val_im_s2[VB-1] ? -val_im_s2 : val_im_s2;
		ctl_m        = ctl_s2;
		ctl_m.neg_re = val_re_s2[VB-1];
		ctl_m.neg_im = val_im_s2[VB-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			ctl_s3    <= ctl_m;
			val_re_s3 <= val_re_s2;
			val_im_s3 <= val_im_s2;
			den_s3    <= den_s2;
			mag_re_s3 <= abs_re[DW-1:0];
			mag_im_s3 <= abs_im[DW-1:0];
		end
	end

	// Stage 4: the scaled dividend splits into a head that must stay below the
	// divisor (otherwise the quotient overflows) and a tail fed in bit by bit.
	logic [DVW-1:0] dv_re, dv_im;
	logic [CW-1:0]  hd_re, hd_im, den_x;
	ctl_t           ctl_o;

	always_comb begin
		dv_re        = DVW'(mag_re_s3) << F;
		dv_im        = DVW'(mag_im_s3) << F;
		hd_re        = CW'(dv_re[DVW-1:QB]);
		hd_im        = CW'(dv_im[DVW-1:QB]);
		den_x        = CW'(den_s3);
		ctl_o        = ctl_s3;
		ctl_o.ovf_re = (hd_re >= den_x);
		ctl_o.ovf_im = (hd_im >= den_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (rdy4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && valid_s3) begin
			ctl_s4    <= ctl_o;
			val_re_s4 <= val_re_s3;
			val_im_s4 <= val_im_s3;
			den_s4    <= den_s3;
			rem_re_s4 <= hd_re[DW-1:0];
			rem_im_s4 <= hd_im[DW-1:0];
			q_re_s4   <= dv_re[QB-1:0];
			q_im_s4   <= dv_im[QB-1:0];
		end
	end

endmodule

@@ rtl/cau_div_step.sv @@
// ----------------------------------------------------------------------------
// cau_div_step: one restoring division stage
// Develops one quotient bit for the real and the imaginary part of every item;
// the values, divisor and control bits pass through unchanged.
// ----------------------------------------------------------------------------
module cau_div_step import cau_pkg::*; #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	output logic                  ready,
	input  ctl_t                  ctl,
	input  logic signed [2*W+1:0] val_re,
	input  logic signed [2*W+1:0] val_im,
	input  logic [2*W-1:0]        den,
	input  logic [2*W-1:0]        rem_re,
	input  logic [2*W-1:0]        rem_im,
	input  logic [W:0]            q_re,
	input  logic [W:0]            q_im,
	input  logic                  accept,
	output logic                  valid_s1,
	output ctl_t                  ctl_s1,
	output logic signed [2*W+1:0] val_re_s1,
	output logic signed [2*W+1:0] val_im_s1,
	output logic [2*W-1:0]        den_s1,
	output logic [2*W-1:0]        rem_re_s1,
	output logic [2*W-1:0]        rem_im_s1,
	output logic [W:0]            q_re_s1,
	output logic [W:0]            q_im_s1
);

	localparam int DW = 2 * W;
	localparam int QB = W + 1;

	// The quotient register doubles as the dividend tail: its top bit is the
	// next dividend bit and the new quotient bit enters at the bottom.
	function automatic logic [DW+QB-1:0] step(input logic [DW-1:0] rem,
		input logic [QB-1:0] q, input logic [DW-1:0] d);
		logic [DW:0] t;
		logic [DW:0] diff;
		logic        ge;
		t    = {rem, q[QB-1]};
		diff = t - {1'b0, d};
		ge   = (t >= {1'b0, d});
		step = ge ? {diff[DW-1:0], q[QB-2:0], 1'b1} : {t[DW-1:0], q[QB-2:0], 1'b0};
	endfunction

	logic [DW+QB-1:0] nx_re, nx_im;

	assign nx_re = step(rem_re, q_re, den);
	assign nx_im = step(rem_im, q_im, den);
	assign ready = !valid_s1 || accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid) begin
			ctl_s1    <= ctl;
			val_re_s1 <= val_re;
			val_im_s1 <= val_im;
			den_s1    <= den;
			rem_re_s1 <= nx_re[DW+QB-1:QB];
			rem_im_s1 <= nx_im[DW+QB-1:QB];
			q_re_s1   <= nx_re[QB-1:0];
			q_im_s1   <= nx_im[QB-1:0];
		end
	end

endmodule

@@ rtl/cau_sat.sv @@
// ----------------------------------------------------------------------------
// cau_sat: saturation and output register
// Clips each result part to the signed word range, applies the divide by zero
// rule and holds the finished item for the downstream side.
// ----------------------------------------------------------------------------
module cau_sat import cau_pkg::*; #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	output logic                  ready,
	input  ctl_t                  ctl,
	input  logic signed [2*W+1:0] val_re,
	input  logic signed [2*W+1:0] val_im,
	input  logic [W:0]            q_re,
	input  logic [W:0]            q_im,
	input  logic                  stall,
	output logic                  res_valid,
	output logic [FIELD_BITS-1:0] res_re,
	output logic [FIELD_BITS-1:0] res_im,
	output logic                  div_zero,
	output logic                  saturated
);

	localparam int VB = 2 * W + 2;
	localparam int QB = W + 1;

	localparam logic signed [VB-1:0] MAXV = {{(VB-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [VB-1:0] MINV = {{(VB-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic signed [W-1:0]  MAXW = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]  MINW = {1'b1, {(W-1){1'b0}}};
	localparam logic [FIELD_BITS-1:0] MAXF = FIELD_BITS'(MAXW);
	localparam logic [FIELD_BITS-1:0] MINF = FIELD_BITS'(MINW);

	function automatic logic [W:0] clamp(input logic signed [VB-1:0] v,
		input logic is_div, input logic neg, input logic ovf, input logic [QB-1:0] q);
		logic signed [VB-1:0] s;
		logic                 clip;
		logic [W-1:0]         r;
		if (is_div) begin
			s = neg ? -$signed(VB'(q)) : $signed(VB'(q));
		end else begin
			s = v;
		end
		if (is_div && ovf) begin
			clip = 1'b1;
			r    = neg ? MINW : MAXW;
		end else if (s > MAXV) begin
			clip = 1'b1;
			r    = MAXW;
		end else if (s < MINV) begin
			clip = 1'b1;
			r    = MINW;
		end else begin
			clip = 1'b0;
			r    = s[W-1:0];
		end
		clamp = {clip, r};
	endfunction

	logic [W:0]          c_re, c_im;
	logic signed [W-1:0] sat_re, sat_im;
	logic                clip;

	always_comb begin
		c_re = clamp(val_re, ctl.is_div, ctl.neg_re, ctl.ovf_re, q_re);
		c_im = clamp(val_im, ctl.is_div, ctl.neg_im, ctl.ovf_im, q_im);
		if (ctl.dz) begin
			sat_re = '0;
			sat_im = '0;
			clip   = 1'b0;
		end else begin
			sat_re = c_re[W-1:0];
			sat_im = c_im[W-1:0];
			clip   = c_re[W] || c_im[W];
		end
	end

	assign ready = !res_valid || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (ready) begin
			res_valid <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid) begin
			res_re    <= FIELD_BITS'(sat_re);
			res_im    <= FIELD_BITS'(sat_im);
			div_zero  <= ctl.dz;
			saturated <= clip;
		end
	end

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && div_zero |-> res_re == '0 && res_im == '0 && !saturated)
		else $error("divide by zero result is not clean zero");

	a_sext: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_re == FIELD_BITS'($signed(res_re[W-1:0]))
			&& res_im == FIELD_BITS'($signed(res_im[W-1:0])))
		else $error("result part exceeds the word range");

	a_sat_edge: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && saturated |-> (res_re == MAXF || res_re == MINF
			|| res_im == MAXF || res_im == MINF))
		else $error("saturated flag without a clipped part");

	a_dz_path: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready && ctl.dz |=> res_valid && div_zero)
		else $error("divide by zero flag lost at the output");

endmodule

@@ rtl/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex add, sub, mul, div, conj, |a|^2
// Pipeline: W + 6 register stages (38 at 32 bits), W being WORD_BITS held to 8..32.
// Throughput: one item per cycle while res_stall is low; the divider is one stage per quotient bit.
// Every operation takes the same path, so results leave in order.
// Reset (arst_n low) clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  op_valid,
	output logic                  op_stall,
	input  logic [CMD_BITS-1:0]   cmd,
	input  logic [FIELD_BITS-1:0] a_re,
	input  logic [FIELD_BITS-1:0] a_im,
	input  logic [FIELD_BITS-1:0] b_re,
	input  logic [FIELD_BITS-1:0] b_im,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [FIELD_BITS-1:0] res_re,
	output logic [FIELD_BITS-1:0] res_im,
	output logic                  div_zero,
	output logic                  saturated
);

	// The arithmetic word is held between 8 and 32 bits and the fraction at
	// no more than 30 bits; operands are the low word bits of each field.
	localparam int W  = (WORD_BITS > 32) ? 32 : ((WORD_BITS < 8) ? 8 : WORD_BITS);
	localparam int F  = (FRAC_BITS > 30) ? 30 : ((FRAC_BITS < 0) ? 0 : FRAC_BITS);
	localparam int QB = W + 1;
	localparam int VB = 2 * W + 2;
	localparam int DW = 2 * W;

	// Stage bundle k sits between the front end (k = 0), the divider steps
	// and the output stage (k = QB). acc[k] says bundle k may move on.
	logic                 st_valid [0:QB];
	logic                 acc      [0:QB];
	ctl_t                 st_ctl   [0:QB];
	logic signed [VB-1:0] st_vre   [0:QB];
	logic signed [VB-1:0] st_vim   [0:QB];
	logic [DW-1:0]        st_den   [0:QB];
	logic [DW-1:0]        st_rre   [0:QB];
	logic [DW-1:0]        st_rim   [0:QB];
	logic [QB-1:0]        st_qre   [0:QB];
	logic [QB-1:0]        st_qim   [0:QB];

	// Multiplies, forms the per-operation sums and prepares the divide.
	cau_front #(.W(W), .F(F)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (op_valid),
		.stall     (op_stall),
		.cmd       (cmd),
		.a_re      (a_re),
		.a_im      (a_im),
		.b_re      (b_re),
		.b_im      (b_im),
		.accept    (acc[0]),
		.valid_s4  (st_valid[0]),
		.ctl_s4    (st_ctl[0]),
		.val_re_s4 (st_vre[0]),
		.val_im_s4 (st_vim[0]),
		.den_s4    (st_den[0]),
		.rem_re_s4 (st_rre[0]),
		.rem_im_s4 (st_rim[0]),
		.q_re_s4   (st_qre[0]),
		.q_im_s4   (st_qim[0])
	);

	// One quotient bit per stage, most significant first. Items that do not
	// divide ride along so that every item sees the same latency.
	for (genvar k = 0; k < QB; k++) begin : g_div
		cau_div_step #(.W(W)) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid     (st_valid[k]),
			.ready     (acc[k]),
			.ctl       (st_ctl[k]),
			.val_re    (st_vre[k]),
			.val_im    (st_vim[k]),
			.den       (st_den[k]),
			.rem_re    (st_rre[k]),
			.rem_im    (st_rim[k]),
			.q_re      (st_qre[k]),
			.q_im      (st_qim[k]),
			.accept    (acc[k+1]),
			.valid_s1  (st_valid[k+1]),
			.ctl_s1    (st_ctl[k+1]),
			.val_re_s1 (st_vre[k+1]),
			.val_im_s1 (st_vim[k+1]),
			.den_s1    (st_den[k+1]),
			.rem_re_s1 (st_rre[k+1]),
			.rem_im_s1 (st_rim[k+1]),
			.q_re_s1   (st_qre[k+1]),
			.q_im_s1   (st_qim[k+1])
		);
	end

	// Saturation and the output register. Each stage only waits when the
	// stage after it is full and not moving, so bubbles are squeezed out and
	// new items keep entering, until the pipeline is full, while a finished item is held at the output.
	cau_sat #(.W(W)) u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (st_valid[QB]),
		.ready     (acc[QB]),
		.ctl       (st_ctl[QB]),
		.val_re    (st_vre[QB]),
		.val_im    (st_vim[QB]),
		.q_re      (st_qre[QB]),
		.q_im      (st_qim[QB]),
		.stall     (res_stall),
		.res_valid (res_valid),
		.res_re    (res_re),
		.res_im    (res_im),
		.div_zero  (div_zero),
		.saturated (saturated)
	);

endmodule

@@ dv/complex_arithmetic_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_tb: self-checking bench for the complex arithmetic unit
// Drives add, sub, mul, div, conjugate and squared-magnitude items through the
// valid/stall input channel, predicts each result with exact wide integer
// arithmetic, and compares every result field in order of arrival.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_tb;
	import cau_pkg::*;

	localparam int FRAC = 16;
	localparam int LATENCY = 38;
	localparam int LONG_HOLD = 300;

	// The two operation codes the package leaves unused; the unit must return zero.
	localparam logic [CMD_BITS-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_BITS-1:0] CMD_SPARE_HI = 3'd7;

	localparam logic [31:0] MOST_NEG = 32'h8000_0000;
	localparam logic [31:0] MOST_POS = 32'h7fff_ffff;
	localparam logic [31:0] ONE_Q    = 32'h0001_0000;

	typedef struct {
		logic [CMD_BITS-1:0] cmd;
		logic [31:0] a_re, a_im, b_re, b_im;
		int unsigned gap;
	} op_item_t;

	typedef struct {
		logic [31:0] re, im;
		logic dz, sat;
	} cplx_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic op_valid = 1'b0;
	logic op_stall;
	logic [CMD_BITS-1:0] cmd = '0;
	logic [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [31:0] res_re, res_im;
	logic div_zero, saturated;

	op_item_t pending_ops[$];
	cplx_result_t awaited_results[$];

	// Controls set by the sequencing block (long_hold_done by the monitor) and read by queueing, driver and monitor.
	bit tx_idle_on = 0;
	bit rx_idle_on = 0;
	bit long_hold_req = 0;
	bit long_hold_done = 0;

	int unsigned mismatches = 0;
	int unsigned ops_sent = 0;
	int unsigned results_seen = 0;
	int unsigned div_zero_seen = 0;
	int unsigned sat_seen = 0;
	int unsigned tx_gap = 0;
	int unsigned rx_wait = 0;
	int unsigned hold_cnt = 0;

	complex_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n),
		.op_valid(op_valid), .op_stall(op_stall),
		.cmd(cmd), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.res_valid(res_valid), .res_stall(res_stall),
		.res_re(res_re), .res_im(res_im),
		.div_zero(div_zero), .saturated(saturated)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Clip a wide value to the signed 32-bit range; the top bit of the
	// return reports whether clipping took place.
	function automatic logic [32:0] clamp_q(logic signed [127:0] v);
		if (v > 128'sd2147483647)
			return {1'b1, MOST_POS};
		if (v < -128'sd2147483648)
			return {1'b1, MOST_NEG};
		return {1'b0, v[31:0]};
	endfunction

	// Exact quotient of num * 2^FRAC / den, truncated toward zero.
	function automatic logic signed [127:0] div_trunc(logic signed [127:0] num,
			logic signed [127:0] den);
		logic signed [127:0] mag;
		logic signed [127:0] q;
		mag = (num < 0) ? -num : num;
		q = (mag <<< FRAC) / den;
		return (num < 0) ? -q : q;
	endfunction

	// Predicts the result of one item. Products are at most 2^62 in size, so
	// 128-bit signed arithmetic holds every intermediate exactly, and an
	// arithmetic right shift gives the floor rounding the multiplier uses.
	function automatic cplx_result_t complex_result(op_item_t it);
		cplx_result_t r;
		logic signed [127:0] ar, ai, br, bi, x, y, den;
		logic [32:0] cr, ci;
		ar = $signed(it.a_re);
		ai = $signed(it.a_im);
		br = $signed(it.b_re);
		bi = $signed(it.b_im);
		x = 0;
		y = 0;
		r.dz = 1'b0;
		case (it.cmd)
			CMD_ADD: begin
				x = ar + br;
				y = ai + bi;
			end
			CMD_SUB: begin
				x = ar - br;
				y = ai - bi;
			end
			CMD_MUL: begin
				x = (ar * br - ai * bi) >>> FRAC;
				y = (ar * bi + ai * br) >>> FRAC;
			end
			CMD_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.dz = 1'b1;
				end else begin
					x = div_trunc(ar * br + ai * bi, den);
					y = div_trunc(ai * br - ar * bi, den);
				end
			end
			CMD_CONJ: begin
				x = ar;
				y = -ai;
			end
			CMD_MAG: begin
				x = (ar * ar + ai * ai) >>> FRAC;
			end
			default: begin
			end
		endcase
		cr = clamp_q(x);
		ci = clamp_q(y);
		r.re = cr[31:0];
		r.im = ci[31:0];
		r.sat = cr[32] | ci[32];
		return r;
	endfunction

	// Operand values: a mix of full-range words, values near unity, mid-size values, small
	// values and the extremes, so that both saturated and exact results occur.
	function automatic logic [31:0] pick_operand();
		logic [31:0] v;
		case ($urandom_range(0, 4))
			0: v = $urandom;
			1: v = $urandom_range(0, 32'h3ffff);
			2: v = $urandom_range(0, 32'hffffff);
			3: begin
				case ($urandom_range(0, 5))
					0: v = MOST_NEG;
					1: v = MOST_POS;
					2: v = '0;
					3: v = '1;
					4: v = ONE_Q;
					default: v = -ONE_Q;
				endcase
				return v;
			end
			default: v = $urandom_range(0, 32'h7ff);
		endcase
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	task automatic queue_op(logic [CMD_BITS-1:0] c, logic [31:0] ar, logic [31:0] ai,
			logic [31:0] br, logic [31:0] bi);
		op_item_t it;
		it.cmd = c;
		it.a_re = ar;
		it.a_im = ai;
		it.b_re = br;
		it.b_im = bi;
		it.gap = tx_idle_on ? $urandom_range(0, 11) : 0;
		pending_ops.push_back(it);
	endtask

	task automatic queue_random_ops(int unsigned count);
		logic [CMD_BITS-1:0] c;
		logic [31:0] br, bi;
		repeat (count) begin
			if ($urandom_range(0, 19) == 0)
				c = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
			else
				c = CMD_BITS'($urandom_range(0, 5));
			br = pick_operand();
			bi = pick_operand();
			// A zero divisor now and then, so the divide-by-zero path stays busy.
			if (c == CMD_DIV && $urandom_range(0, 9) == 0) begin
				br = '0;
				bi = '0;
			end
			queue_op(c, pick_operand(), pick_operand(), br, bi);
		end
	endtask

	// Driver: an item leaves the queue only when the channel is free, and each
	// accepted item is followed by the gap that was drawn for it.
	always @(posedge clk or negedge arst_n) begin
		op_item_t it;
		if (!arst_n) begin
			op_valid <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (op_valid && !op_stall) begin
				awaited_results.push_back(complex_result('{cmd, a_re, a_im, b_re, b_im, 0}));
				ops_sent <= ops_sent + 1;
			end
			if (!op_valid || !op_stall) begin
				if (tx_gap > 0) begin
					op_valid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if (pending_ops.size() > 0) begin
					it = pending_ops.pop_front();
					cmd <= it.cmd;
					a_re <= it.a_re;
					a_im <= it.a_im;
					b_re <= it.b_re;
					b_im <= it.b_im;
					op_valid <= 1'b1;
					tx_gap <= it.gap;
				end else begin
					op_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest prediction and
	// drives the receiver stall, including one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		cplx_result_t want;
		int unsigned w;
		if (!arst_n) begin
			res_stall <= 1'b0;
			rx_wait <= 0;
			hold_cnt <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				results_seen <= results_seen + 1;
				if (awaited_results.size() == 0) begin
					$error("unexpected result re=%h im=%h", res_re, res_im);
					mismatches <= mismatches + 1;
				end else begin
					want = awaited_results.pop_front();
					if (want.dz)
						div_zero_seen <= div_zero_seen + 1;
					if (want.sat)
						sat_seen <= sat_seen + 1;
					if (res_re !== want.re || res_im !== want.im ||
							div_zero !== want.dz || saturated !== want.sat)
						mismatches <= mismatches + 1;
					if (res_re !== want.re)
						$error("res_re expected %h got %h", want.re, res_re);
					if (res_im !== want.im)
						$error("res_im expected %h got %h", want.im, res_im);
					if (div_zero !== want.dz)
						$error("div_zero expected %b got %b", want.dz, div_zero);
					if (saturated !== want.sat)
						$error("saturated expected %b got %b", want.sat, saturated);
				end
			end
			if (hold_cnt > 0) begin
				res_stall <= 1'b1;
				hold_cnt <= hold_cnt - 1;
			end else if (long_hold_req && !long_hold_done) begin
				long_hold_done <= 1'b1;
				hold_cnt <= LONG_HOLD;
				res_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				res_stall <= 1'b1;
				rx_wait <= rx_wait - 1;
			end else if (res_valid && !res_stall && rx_idle_on) begin
				w = $urandom_range(0, 11);
				rx_wait <= (w > 0) ? w - 1 : 0;
				res_stall <= (w > 0);
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Waits until the queue is empty and every predicted result has arrived.
	task automatic drain();
		while (pending_ops.size() > 0 || op_valid || awaited_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items: every operation, field extremes and the special cases.
		queue_op(CMD_ADD, MOST_POS, MOST_NEG, MOST_POS, MOST_NEG);
		queue_op(CMD_ADD, ONE_Q, -ONE_Q, ONE_Q, ONE_Q);
		queue_op(CMD_SUB, MOST_NEG, MOST_POS, MOST_POS, MOST_NEG);
		queue_op(CMD_SUB, '0, '1, '1, '0);
		queue_op(CMD_MUL, ONE_Q, ONE_Q, ONE_Q, -ONE_Q);
		queue_op(CMD_MUL, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
		queue_op(CMD_MUL, '1, '0, 32'd1, '0);
		queue_op(CMD_MUL, MOST_POS, MOST_NEG, MOST_POS, MOST_POS);
		queue_op(CMD_DIV, ONE_Q, '0, '0, '0);
		queue_op(CMD_DIV, MOST_POS, MOST_NEG, 32'd1, '0);
		queue_op(CMD_DIV, ONE_Q, ONE_Q, ONE_Q, -ONE_Q);
		queue_op(CMD_DIV, '1, 32'd3, MOST_NEG, MOST_NEG);
		queue_op(CMD_DIV, 32'd7, '0, 32'd3, '0);
		queue_op(CMD_DIV, -32'd7, '0, 32'd3, '0);
		queue_op(CMD_CONJ, MOST_NEG, MOST_NEG, '0, '0);
		queue_op(CMD_CONJ, MOST_POS, MOST_POS, '1, '1);
		queue_op(CMD_MAG, MOST_NEG, MOST_NEG, '0, '0);
		queue_op(CMD_MAG, '1, 32'd1, '0, '0);
		queue_op(CMD_MAG, ONE_Q, -ONE_Q, '0, '0);
		queue_op(CMD_SPARE_LO, MOST_POS, MOST_POS, MOST_POS, MOST_POS);
		queue_op(CMD_SPARE_HI, '1, '1, '1, '1);
		drain();

		// Random items with idling on both sides; the sender then pauses
		// until every result is back.
		tx_idle_on = 1;
		rx_idle_on = 1;
		queue_random_ops(600);
		drain();

		// Back-to-back items against a long receiver hold-off so the
		// pipeline fills and pushes back on the input.
		tx_idle_on = 0;
		rx_idle_on = 0;
		long_hold_req = 1;
		queue_random_ops(400);
		drain();

		tx_idle_on = 1;
		rx_idle_on = 1;
		queue_random_ops(630);
		drain();

		repeat (LATENCY + 20) @(posedge clk);
		$display("Checked %0d results from %0d items (%0d divide-by-zero, %0d saturated).",
			results_seen, ops_sent, div_zero_seen, sat_seen);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timed out with %0d results outstanding.", awaited_results.size());
		$display("status: fail");
		$finish;
	end

endmodule
